// File: src/atv_pkg.sv
// Shared types and constants for the address text validator.
// No dependencies; atv_cfg, atv_core and address_text_validator import this package.
package atv_pkg;

    // Configuration port geometry
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    // Register word indexes (paddr[2])
    localparam logic CFG_IDX_MAC_MODE = 1'b0;

    // Character codes
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    // Group and separator limits
    localparam logic [2:0] DEC_MAX_LEN    = 3'd3;
    localparam logic [2:0] DEC_LEN_SAT    = 3'd4;
    localparam logic [2:0] DOT_SAT        = 3'd4;
    localparam logic [2:0] DOT_NEEDED     = 3'd3;
    localparam logic [9:0] DEC_MAX_VALUE  = 10'd255;
    localparam logic [2:0] HEX_LEN_SAT    = 3'd5;
    localparam logic [2:0] HEX_MAX_IPV6   = 3'd4;
    localparam logic [2:0] HEX_MAX_MAC    = 3'd2;
    localparam logic [3:0] COLON_SAT      = 4'd8;
    localparam logic [3:0] COLON_LIM_IPV6 = 4'd7;
    localparam logic [3:0] COLON_LIM_MAC  = 4'd5;
    localparam logic [3:0] DEC_LAST_GROUP = 4'd4;

    // Verdict codes
    typedef enum logic [2:0] {
        VERD_BAD_IPV4 = 3'd0,
        VERD_IPV4     = 3'd1,
        VERD_BAD_IPV6 = 3'd2,
        VERD_IPV6     = 3'd3,
        VERD_BAD_MAC  = 3'd4,
        VERD_MAC      = 3'd5,
        VERD_NEITHER  = 3'd6
    } verdict_t;

    // One input word held in the input stage
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_word_t;

    // One result word
    typedef struct packed {
        verdict_t   verdict;
        logic [3:0] bad_group;
    } result_t;

endpackage

// File: src/atv_in_if.sv
// Character input channel: valid/ready handshake with one character word.
// No dependencies.
interface atv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: src/atv_out_if.sv
// Verdict output channel: valid/ready handshake with one result word.
// No dependencies.
interface atv_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [3:0] bad_group;

    modport source (output valid, output verdict, output bad_group, input ready);
    modport sink   (input valid, input verdict, input bad_group, output ready);
endinterface

// File: src/atv_cfg.sv
// APB-style configuration register block holding mac_mode.
// Depends on atv_pkg.
module atv_cfg
    import atv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic               mac_mode
);

    logic mac_mode_reg;
    logic mac_mode_next;
    logic wr_fire;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready;

    // Decode the write by word index
    always_comb
    begin
        mac_mode_next = mac_mode_reg;
        if (wr_fire && paddr[2] == CFG_IDX_MAC_MODE)
        begin
            mac_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_mode_reg <= 1'b0;
        end
        else
        begin
            mac_mode_reg <= mac_mode_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == CFG_IDX_MAC_MODE)
        begin
            prdata = {{(PDATA_W-1){1'b0}}, mac_mode_reg};
        end
    end

    assign mac_mode = mac_mode_reg;

endmodule

// File: src/atv_core.sv
// Per-character group checker: decimal and hex scans side by side, verdict on last char.
// Depends on atv_pkg.
module atv_core
    import atv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  char_word_t word,
    input  logic       mac_mode,
    output result_t    result
);

    typedef struct packed {
        logic       saw_dot;
        logic       saw_colon;
        logic [2:0] dec_group_len;
        logic [9:0] dec_group_value;
        logic       dec_leading_zero;
        logic       dec_bad_char;
        logic [2:0] dot_count;
        logic       dec_failed;
        logic [3:0] dec_fail_group;
        logic [2:0] hex_group_len;
        logic       hex_bad_char;
        logic [3:0] colon_count;
        logic       hex_failed;
        logic [3:0] hex_fail_group;
    } scan_state_t;

    scan_state_t st_reg;
    scan_state_t st_next;

    function automatic logic dec_group_ok(input scan_state_t s);
        logic ok;
        begin
            ok = (s.dec_group_len != 3'd0) && (s.dec_group_len <= DEC_MAX_LEN)
                 && !s.dec_bad_char
                 && !(s.dec_leading_zero && s.dec_group_len > 3'd1)
                 && (s.dec_group_value <= DEC_MAX_VALUE);
            return ok;
        end
    endfunction

    function automatic logic hex_group_ok(input scan_state_t s, input logic mac);
        logic [2:0] max_len;
        begin
            max_len = mac ? HEX_MAX_MAC : HEX_MAX_IPV6;
            return (s.hex_group_len != 3'd0) && (s.hex_group_len <= max_len)
                   && !s.hex_bad_char;
        end
    endfunction

    scan_state_t s;
    logic [7:0]  c;
    logic        is_digit;
    logic        is_hex;
    logic [3:0]  colon_lim;
    verdict_t    bad_code;
    verdict_t    good_code;

    // Update scan state with one character, then judge on the last one
    always_comb
    begin
        s         = st_reg;
        c         = word.char_code;
        is_digit  = (c >= CH_0) && (c <= CH_9);
        is_hex    = is_digit || ((c >= CH_LC_A) && (c <= CH_LC_F))
                    || ((c >= CH_UC_A) && (c <= CH_UC_F));
        colon_lim = mac_mode ? COLON_LIM_MAC : COLON_LIM_IPV6;
        bad_code  = mac_mode ? VERD_BAD_MAC : VERD_BAD_IPV6;
        good_code = mac_mode ? VERD_MAC : VERD_IPV6;

        // Decimal scan
        if (c == CH_DOT)
        begin
            s.saw_dot = 1'b1;
            if (st_reg.dot_count < DOT_SAT)
            begin
                if (!st_reg.dec_failed && !dec_group_ok(st_reg))
                begin
                    s.dec_failed     = 1'b1;
                    s.dec_fail_group = {1'b0, st_reg.dot_count} + 4'd1;
                end
                s.dot_count = st_reg.dot_count + 3'd1;
            end
            s.dec_group_len    = 3'd0;
            s.dec_group_value  = 10'd0;
            s.dec_leading_zero = 1'b0;
            s.dec_bad_char     = 1'b0;
        end
        else
        begin
            if (is_digit)
            begin
                if (st_reg.dec_group_len == 3'd0 && c == CH_0)
                begin
                    s.dec_leading_zero = 1'b1;
                end
                // value stays below 100 here, so x10 plus a digit fits 10 bits
                if (st_reg.dec_group_len < DEC_MAX_LEN)
                begin
                    s.dec_group_value = {st_reg.dec_group_value[6:0], 3'b000}
                                      + {st_reg.dec_group_value[8:0], 1'b0}
                                      + {6'd0, c[3:0]};
                end
            end
            else
            begin
                s.dec_bad_char = 1'b1;
            end
            if (st_reg.dec_group_len < DEC_LEN_SAT)
            begin
                s.dec_group_len = st_reg.dec_group_len + 3'd1;
            end
        end

        // Hex scan
        if (c == CH_COLON)
        begin
            s.saw_colon = 1'b1;
            if (st_reg.colon_count <= colon_lim)
            begin
                if (!st_reg.hex_failed && !hex_group_ok(st_reg, mac_mode))
                begin
                    s.hex_failed     = 1'b1;
                    s.hex_fail_group = st_reg.colon_count + 4'd1;
                end
            end
            if (st_reg.colon_count < COLON_SAT)
            begin
                s.colon_count = st_reg.colon_count + 4'd1;
            end
            s.hex_group_len = 3'd0;
            s.hex_bad_char  = 1'b0;
        end
        else
        begin
            if (!is_hex)
            begin
                s.hex_bad_char = 1'b1;
            end
            if (st_reg.hex_group_len < HEX_LEN_SAT)
            begin
                s.hex_group_len = st_reg.hex_group_len + 3'd1;
            end
        end

        // Verdict from the updated state
        result.bad_group = 4'd0;
        if (!mac_mode && s.saw_dot)
        begin
            result.verdict = VERD_BAD_IPV4;
            if (s.dec_failed)
            begin
                result.bad_group = s.dec_fail_group;
            end
            else if (s.dot_count != DOT_NEEDED)
            begin
                result.bad_group = 4'd0;
            end
            else if (!dec_group_ok(s))
            begin
                result.bad_group = DEC_LAST_GROUP;
            end
            else
            begin
                result.verdict = VERD_IPV4;
            end
        end
        else if (mac_mode || s.saw_colon)
        begin
            result.verdict = bad_code;
            if (s.hex_failed)
            begin
                result.bad_group = s.hex_fail_group;
            end
            else if (s.colon_count != colon_lim)
            begin
                result.bad_group = 4'd0;
            end
            else if (!hex_group_ok(s, mac_mode))
            begin
                result.bad_group = colon_lim + 4'd1;
            end
            else
            begin
                result.verdict = good_code;
            end
        end
        else
        begin
            result.verdict = VERD_NEITHER;
        end

        // Clear after the verdict, hold when idle
        st_next = st_reg;
        if (step)
        begin
            st_next = word.last_char ? '0 : s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

// File: src/address_text_validator.sv
// Address text validator: checks IPv4/IPv6 or MAC address text, one character a word.
// Throughput: one character per cycle, sustained, with the output side taking words.
// A last character passes through the input stage and then the verdict register before its
// verdict is valid. The input stage stalls only while it holds a last character
// and the verdict register is full and not being read. Reset (rst_n, async low) clears
// the scan state, the valid flags and mac_mode; no clearing pass is needed.
module address_text_validator
    import atv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    atv_in_if.sink             char_in,
    atv_out_if.source          verdict_out
);

    logic       mac_mode;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    char_word_t s1_word_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;
    result_t    core_res;
    logic       out_free;
    logic       proc_fire;
    logic       accept;
    logic       load_out;

    atv_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .mac_mode (mac_mode)
    );

    atv_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (proc_fire),
        .word     (s1_word_reg),
        .mac_mode (mac_mode),
        .result   (core_res)
    );

    // Advance the input stage unless a last char waits on a full verdict register
    assign out_free      = !out_valid_reg || verdict_out.ready;
    assign proc_fire     = s1_valid_reg && (!s1_word_reg.last_char || out_free);
    assign load_out      = proc_fire && s1_word_reg.last_char;
    assign char_in.ready = !s1_valid_reg || proc_fire;
    assign accept        = char_in.valid && char_in.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdict_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg.char_code <= char_in.char_code;
            s1_word_reg.last_char <= char_in.last_char;
        end
        if (load_out)
        begin
            out_res_reg <= core_res;
        end
    end

    assign verdict_out.valid     = out_valid_reg;
    assign verdict_out.verdict   = out_res_reg.verdict;
    assign verdict_out.bad_group = out_res_reg.bad_group;

    // A non-last character never produces a verdict word
    a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_word_reg.last_char && !out_valid_reg |=> !out_valid_reg)
        else $error("verdict word appeared without a last character");

    // Input stalls only behind a pending last char and a blocked verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !char_in.ready |-> s1_valid_reg && s1_word_reg.last_char
                           && out_valid_reg && !verdict_out.ready)
        else $error("input stalled without cause");

    // Good or neither verdicts carry no failing group
    a_clean_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.verdict == VERD_IPV4
                          || out_res_reg.verdict == VERD_IPV6
                          || out_res_reg.verdict == VERD_MAC
                          || out_res_reg.verdict == VERD_NEITHER)
        |-> out_res_reg.bad_group == 4'd0)
        else $error("good verdict reports a failing group");

    // A last char processed loads the verdict register
    a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("last character processed but no verdict word");

endmodule

// File: sim/tb_address_text_validator.sv
`timescale 1ns / 100ps
// Self-checking testbench for address_text_validator: streams address strings
// over the character channel and checks every verdict against a local model.
// Depends on atv_pkg, atv_in_if, atv_out_if and address_text_validator from src.
module tb_address_text_validator;
    import atv_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_CHARS  = 650;
    localparam int PHASES        = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int TIMEOUT_NS    = 2_000_000;

    localparam logic [PADDR_W-1:0] ADDR_MAC_MODE = {CFG_IDX_MAC_MODE, 2'b00};

    // Predicts one verdict per string and holds the verdicts still owed by the block
    class address_verdict_board;
        bit          mac_mode;
        bit          saw_dot;
        bit          saw_colon;
        logic [2:0]  dec_len;
        logic [9:0]  dec_val;
        bit          dec_lead0;
        bit          dec_bad;
        logic [2:0]  dot_cnt;
        bit          dec_fail;
        logic [3:0]  dec_fail_grp;
        logic [2:0]  hex_len;
        bit          hex_bad;
        logic [3:0]  colon_cnt;
        bit          hex_fail;
        logic [3:0]  hex_fail_grp;
        result_t     expected_verdicts[$];
        int unsigned verdicts_checked;
        int unsigned failures;
        int unsigned verdict_hist[7];

        function void clear_scan();
            saw_dot      = 0;
            saw_colon    = 0;
            dec_len      = '0;
            dec_val      = '0;
            dec_lead0    = 0;
            dec_bad      = 0;
            dot_cnt      = '0;
            dec_fail     = 0;
            dec_fail_grp = '0;
            hex_len      = '0;
            hex_bad      = 0;
            colon_cnt    = '0;
            hex_fail     = 0;
            hex_fail_grp = '0;
        endfunction

        function bit is_hex(logic [7:0] c);
            return (c >= CH_0 && c <= CH_9) || (c >= CH_LC_A && c <= CH_LC_F)
                || (c >= CH_UC_A && c <= CH_UC_F);
        endfunction

        function bit dec_group_good();
            if (dec_len == 0 || dec_len > DEC_MAX_LEN || dec_bad)
                return 0;
            if (dec_lead0 && dec_len > 1)
                return 0;
            return dec_val <= DEC_MAX_VALUE;
        endfunction

        function bit hex_group_good();
            logic [2:0] max_len;
            max_len = mac_mode ? HEX_MAX_MAC : HEX_MAX_IPV6;
            return hex_len != 0 && hex_len <= max_len && !hex_bad;
        endfunction

        // Advance both group scanners by one accepted character
        function void note_char(logic [7:0] c, logic last);
            logic [3:0] lim;
            result_t    r;

            // Decimal side: a dot closes the group
            if (c == CH_DOT) begin
                saw_dot = 1;
                if (dot_cnt < DOT_SAT) begin
                    if (!dec_fail && !dec_group_good()) begin
                        dec_fail     = 1;
                        dec_fail_grp = {1'b0, dot_cnt} + 4'd1;
                    end
                    dot_cnt = dot_cnt + 3'd1;
                end
                dec_len   = '0;
                dec_val   = '0;
                dec_lead0 = 0;
                dec_bad   = 0;
            end
            else begin
                if (c >= CH_0 && c <= CH_9) begin
                    if (dec_len == 0 && c == CH_0)
                        dec_lead0 = 1;
                    if (dec_len < DEC_MAX_LEN)
                        dec_val = dec_val * 10 + 10'(c - CH_0);
                end
                else
                    dec_bad = 1;
                if (dec_len < DEC_LEN_SAT)
                    dec_len = dec_len + 3'd1;
            end

            // Hex side: a colon closes the group, which is checked while the count is at most the mode's limit
            lim = mac_mode ? COLON_LIM_MAC : COLON_LIM_IPV6;
            if (c == CH_COLON) begin
                saw_colon = 1;
                if (colon_cnt <= lim && !hex_fail && !hex_group_good()) begin
                    hex_fail     = 1;
                    hex_fail_grp = colon_cnt + 4'd1;
                end
                if (colon_cnt < COLON_SAT)
                    colon_cnt = colon_cnt + 4'd1;
                hex_len = '0;
                hex_bad = 0;
            end
            else begin
                if (!is_hex(c))
                    hex_bad = 1;
                if (hex_len < HEX_LEN_SAT)
                    hex_len = hex_len + 3'd1;
            end

            if (!last)
                return;

            // End of string: pick the scanner that counts and form the verdict
            r.bad_group = '0;
            if (!mac_mode && saw_dot) begin
                r.verdict = VERD_BAD_IPV4;
                if (dec_fail)
                    r.bad_group = dec_fail_grp;
                else if (dot_cnt == DOT_NEEDED) begin
                    if (!dec_group_good())
                        r.bad_group = DEC_LAST_GROUP;
                    else
                        r.verdict = VERD_IPV4;
                end
            end
            else if (mac_mode || saw_colon) begin
                r.verdict = mac_mode ? VERD_BAD_MAC : VERD_BAD_IPV6;
                if (hex_fail)
                    r.bad_group = hex_fail_grp;
                else if (colon_cnt == lim) begin
                    if (!hex_group_good())
                        r.bad_group = lim + 4'd1;
                    else
                        r.verdict = mac_mode ? VERD_MAC : VERD_IPV6;
                end
            end
            else
                r.verdict = VERD_NEITHER;
            expected_verdicts.push_back(r);
            clear_scan();
        endfunction

        // Compare one accepted verdict word against the oldest prediction
        function void check_verdict(result_t got);
            result_t want;
            if (expected_verdicts.size() == 0) begin
                $error("unexpected verdict word: verdict %0d, bad_group %0d",
                       got.verdict, got.bad_group);
                failures++;
                return;
            end
            want = expected_verdicts.pop_front();
            verdicts_checked++;
            verdict_hist[want.verdict]++;
            if (got.verdict !== want.verdict) begin
                $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                failures++;
            end
            if (got.bad_group !== want.bad_group) begin
                $error("bad_group: expected %0d, got %0d", want.bad_group, got.bad_group);
                failures++;
            end
        endfunction
    endclass

    typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT, RX_PATTERN} rx_style_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    atv_in_if  char_in();
    atv_out_if verdict_out();

    address_verdict_board board;
    logic [7:0]  text_buf[$];
    int          burst_left;
    int          stall_left;
    rx_style_t   stall_style;
    int unsigned chars_taken;
    int unsigned mode_writes;
    int unsigned reg_failures;

    address_text_validator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .char_in     (char_in),
        .verdict_out (verdict_out)
    );

    always #CLK_HALF clk = ~clk;

    // Sample both channels at the rising edge; check output before noting input
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n) begin
            if (verdict_out.valid && verdict_out.ready) begin
                got.verdict   = verdict_t'(verdict_out.verdict);
                got.bad_group = verdict_out.bad_group;
                board.check_verdict(got);
            end
            if (char_in.valid && char_in.ready) begin
                board.note_char(char_in.char_code, char_in.last_char);
                chars_taken++;
            end
        end
    end

    // Receiver: switch between stall styles, each kept for a random stretch
    always @(negedge clk)
    begin
        if (stall_left == 0) begin
            stall_style = rx_style_t'($urandom_range(0, 3));
            stall_left  = $urandom_range(16, 96);
        end
        else
            stall_left--;
        case (stall_style)
            RX_OPEN:  verdict_out.ready <= 1'b1;
            RX_COIN:  verdict_out.ready <= 1'($urandom_range(0, 1));
            RX_TIGHT: verdict_out.ready <= ($urandom_range(0, 4) == 0);
            default:  verdict_out.ready <= ((stall_left % 7) < 3);
        endcase
    end

    // Drive one character; valid stays high into the next call within a burst
    task send_char(input logic [7:0] c, input logic last);
        if (burst_left == 0) begin
            char_in.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(60, 120);
            else
                burst_left = $urandom_range(1, 24);
        end
        char_in.valid     <= 1'b1;
        char_in.char_code <= c;
        char_in.last_char <= last;
        burst_left--;
        @(posedge clk);
        while (!char_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    // Hold the sender until every owed verdict has come, then let the block settle
    task drain();
        char_in.valid <= 1'b0;
        while (board.expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write mac_mode while idle, then read it back
    task write_mode(input bit m);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAC_MODE;
        pwdata  <= PDATA_W'(m);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.mac_mode = m;
        mode_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== PDATA_W'(m)) begin
            $error("mac_mode readback: expected %0h, got %0h", PDATA_W'(m), prdata);
            reg_failures++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int idx;
        idx = $urandom_range(0, 21);
        if (idx < 10)
            return CH_0 + 8'(idx);
        else if (idx < 16)
            return CH_LC_A + 8'(idx - 10);
        return CH_UC_A + 8'(idx - 16);
    endfunction

    function automatic logic [7:0] rand_non_digit();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CH_0 && c <= CH_9) || c == CH_DOT);
        return c;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (board.is_hex(c) || c == CH_COLON);
        return c;
    endfunction

    // Mostly good decimal groups, with every kind of broken group mixed in
    function automatic void make_dec_group();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            v = $urandom_range(0, 9);
            if (v == 0)
                v = 0;
            else if (v == 1)
                v = 255;
            else
                v = $urandom_range(0, 255);
            push_str($sformatf("%0d", v));
        end
        else if (pick < 80)
            push_str($sformatf("0%0d", $urandom_range(0, 99)));
        else if (pick < 85)
            push_str($sformatf("%0d", $urandom_range(256, 999)));
        else if (pick < 89)
            push_str($sformatf("%0d", $urandom_range(1000, 99999)));
        else if (pick < 93)
            return;
        else if (pick < 97) begin
            push_str($sformatf("%0d", $urandom_range(0, 99)));
            text_buf.insert(text_buf.size() - $urandom_range(0, 1), rand_non_digit());
        end
        else begin
            push_str($sformatf("%0d", $urandom_range(1, 99)));
            text_buf.push_back(CH_COLON);
        end
    endfunction

    function automatic void make_hex_group(int max_len);
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 82)
            len = $urandom_range(1, max_len);
        else if (pick < 88)
            len = $urandom_range(max_len + 1, 6);
        else if (pick < 93)
            len = 0;
        else
            len = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++)
            text_buf.push_back(rand_hex_char());
        if (pick >= 93)
            text_buf[text_buf.size() - 1 - $urandom_range(0, len - 1)] = rand_non_hex();
    endfunction

    function automatic int group_count(int nominal);
        if ($urandom_range(0, 4) != 0)
            return nominal;
        return $urandom_range((nominal > 2) ? nominal - 2 : 1, nominal + 2);
    endfunction

    function automatic void make_ipv4_text();
        int groups;
        groups = group_count(4);
        for (int g = 0; g < groups; g++) begin
            if (g > 0)
                text_buf.push_back(CH_DOT);
            make_dec_group();
        end
    endfunction

    function automatic void make_hex_text(int nominal, int max_len);
        int groups;
        groups = group_count(nominal);
        for (int g = 0; g < groups; g++) begin
            if (g > 0)
                text_buf.push_back(CH_COLON);
            make_hex_group(max_len);
        end
    endfunction

    // Free text: either plain words with no separator or raw bytes
    function automatic void make_noise();
        int len;
        bit plain;
        len   = $urandom_range(1, 10);
        plain = $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            if (plain)
                text_buf.push_back($urandom_range(0, 1) ? rand_hex_char() : rand_non_hex());
            else if ($urandom_range(0, 4) < 2)
                text_buf.push_back($urandom_range(0, 1) ? CH_DOT : CH_COLON);
            else
                text_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (plain)
            foreach (text_buf[i])
                if (text_buf[i] == CH_DOT || text_buf[i] == CH_COLON)
                    text_buf[i] = CH_UC_A;
    endfunction

    function automatic void make_address(bit mac);
        int pick;
        pick = $urandom_range(0, 99);
        if (mac) begin
            if (pick < 65)
                make_hex_text(COLON_LIM_MAC + 1, HEX_MAX_MAC);
            else if (pick < 72)
                make_ipv4_text();
            else if (pick < 82)
                make_hex_text(COLON_LIM_IPV6 + 1, HEX_MAX_IPV6);
            else
                make_noise();
        end
        else begin
            if (pick < 40)
                make_ipv4_text();
            else if (pick < 70)
                make_hex_text(COLON_LIM_IPV6 + 1, HEX_MAX_IPV6);
            else if (pick < 80)
                make_hex_text(COLON_LIM_MAC + 1, HEX_MAX_MAC);
            else
                make_noise();
        end
        if (text_buf.size() == 0)
            text_buf.push_back(rand_hex_char());
    endfunction

    initial
    begin
        int unsigned random_chars;
        int unsigned target;
        bit          m;

        clk                = 1'b0;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        char_in.valid      = 1'b0;
        char_in.char_code  = '0;
        char_in.last_char  = 1'b0;
        verdict_out.ready  = 1'b0;
        board              = new();
        board.clear_scan();
        burst_left         = 0;
        stall_left         = 0;
        stall_style        = RX_OPEN;
        chars_taken        = 0;
        mode_writes        = 0;
        reg_failures       = 0;
        random_chars       = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: group value extremes, short strings, separator as last char
        write_mode(1'b0);
        push_str("0.255.9.1");
        send_text();
        push_str("a:F");
        send_text();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        push_str(".");
        send_text();

        // Directed: switch mac_mode in the middle of a string
        write_mode(1'b1);
        send_char("a", 1'b0);
        send_char(":", 1'b0);
        write_mode(1'b0);
        send_char("b", 1'b1);

        // Random phases, mac_mode set in the first and last phase and clear in the others
        for (int phase = 0; phase < PHASES; phase++) begin
            m = (phase == 0 || phase == PHASES - 1);
            write_mode(m);
            target = (phase + 1) * RANDOM_CHARS / PHASES;
            while (random_chars < target) begin
                make_address(m);
                random_chars += text_buf.size();
                send_text();
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
        end
        drain();

        $display("Checked %0d verdicts over %0d characters and %0d mac_mode writes.",
                 board.verdicts_checked, chars_taken, mode_writes);
        $display("Good IPv4 %0d, good IPv6 %0d, good MAC %0d, neither %0d, rest rejected.",
                 board.verdict_hist[VERD_IPV4], board.verdict_hist[VERD_IPV6],
                 board.verdict_hist[VERD_MAC], board.verdict_hist[VERD_NEITHER]);
        if (board.failures == 0 && reg_failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $error("timeout with %0d verdicts still owed", board.expected_verdicts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
